// ===== hw/rtl/ffca_pkg.sv =====
`default_nettype none
package ffca_pkg;

  // Pool geometry: one bit per slot, packed into narrow memory words
  localparam int SLOTS   = 65536;
  localparam int SLOT_W  = 17;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int WORD_W  = 8;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int ADDR_W  = IDX_W - BIT_W;

  localparam logic [SLOT_W-1:0] POOL_RESET = SLOT_W'(65536);
  localparam logic [SLOT_W-1:0] POOL_MAX   = SLOT_W'(SLOTS);

  // Request codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Register map
  localparam logic [1:0] REG_POOL_SIZE = 2'd0;

  // Scanner result for one word
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_start;
    logic [SLOT_W-1:0] run;
    logic [SLOT_W-1:0] run_start;
  } scan_res_t;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_MARK_RD = 6'b001000,
    ST_MARK_WR = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ffca_if.sv =====
`default_nettype none
interface ffca_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [ffca_pkg::SLOT_W-1:0]   start_req;
  logic [ffca_pkg::SLOT_W-1:0]   run_length;
  modport source (output valid, mode, start_req, run_length, input ready);
  modport sink (input valid, mode, start_req, run_length, output ready);
endinterface

interface ffca_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffca_pkg::SLOT_W-1:0]   first_slot;
  logic                          found;
  modport source (output valid, first_slot, found, input ready);
  modport sink (input valid, first_slot, found, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/first_fit_contiguous_slot_allocator_core.sv =====
`default_nettype none
// Channel   Direction  Handshake      Payload
// req       in         valid/ready    mode, start_req, run_length
// rsp       out        valid/ready    first_slot, found (one per allocate)
// apb       in         psel/penable   pool_size at byte address 0
//
// The pool is a bitmap in one memory of 8-bit words (1 = free), 8192 words.
// Allocate scans words from the bottom, one word per cycle, then marks the run
// used with a read (MARK_RD) and a write (MARK_WR) per word. Free marks its
// range free the same way, with a read and a write per word touched.
// Reset and every pool_size write run a clearing pass over all 8192 words, no req.
// A held result does not block the next req; a new result waits for the slot.
module first_fit_contiguous_slot_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  ffca_req_if.sink         req,
  ffca_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SW = ffca_pkg::SLOT_W;
  localparam int AW = ffca_pkg::ADDR_W;
  localparam int IW = ffca_pkg::IDX_W;
  localparam int WW = ffca_pkg::WORD_W;
  localparam int BW = ffca_pkg::BIT_W;

  ffca_pkg::state_t   state;
  ffca_pkg::scan_res_t sres;

  logic [SW-1:0] pool_size;
  logic [SW-1:0] pool_n;
  logic [SW-1:0] pool_n_next;
  logic          cfg_wr;

  logic [AW-1:0] clr_addr;
  logic [AW:0]   rd_addr;
  logic          dv;
  logic [AW-1:0] data_addr;
  logic [SW-1:0] len;
  logic [SW-1:0] run;
  logic [SW-1:0] run_start;
  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  logic          fill;
  logic [AW-1:0] mark_addr;
  logic          res_found;
  logic [SW-1:0] res_slot;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;
  logic [WW-1:0] clr_word;
  logic [WW-1:0] mark_word;

  logic [SW:0]   free_end;
  logic [SW:0]   free_s;
  logic [SW:0]   free_e;
  logic          req_acc;
  logic [SW-1:0] alloc_end;

  ffca_ram #(.DW(WW), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffca_scan u_scan (
    .word         (ram_rdata),
    .waddr        (data_addr),
    .len          (len),
    .run_in       (run),
    .run_start_in (run_start),
    .res          (sres)
  );

  // Register port
  assign pready = 1'b1;
  assign prdata = {15'd0, pool_size};
  assign cfg_wr = psel && penable && pwrite && (paddr == ffca_pkg::REG_POOL_SIZE);

  always_comb begin
    pool_n_next = pwdata[SW-1:0];
    if (pool_n_next == '0) begin
      pool_n_next = SW'(1);
    end else if (pool_n_next > ffca_pkg::POOL_MAX) begin
      pool_n_next = ffca_pkg::POOL_MAX;
    end
  end

  // Word images for clearing and marking
  always_comb begin
    for (int b = 0; b < WW; b++) begin
      clr_word[b]  = SW'({clr_addr, BW'(b)}) < pool_n;
      if (IW'({mark_addr, BW'(b)}) >= lo && IW'({mark_addr, BW'(b)}) <= hi) begin
        mark_word[b] = fill;
      end else begin
        mark_word[b] = ram_rdata[b];
      end
    end
  end

  // Memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mark_addr;
    ram_wdata = mark_word;
    ram_raddr = mark_addr;
    if (state == ffca_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = clr_word;
    end else if (state == ffca_pkg::ST_MARK_WR) begin
      ram_we    = 1'b1;
    end
    if (state == ffca_pkg::ST_SCAN) begin
      ram_raddr = rd_addr[AW-1:0];
    end
  end

  // Free range clipping
  assign free_end  = {1'b0, req.start_req} + {1'b0, req.run_length} - (SW+1)'(1);
  assign free_s    = (req.start_req == '0) ? (SW+1)'(1) : {1'b0, req.start_req};
  assign free_e    = (free_end > {1'b0, pool_n}) ? {1'b0, pool_n} : free_end;
  assign alloc_end = sres.hit_start + len - SW'(2);

  assign req.ready = (state == ffca_pkg::ST_IDLE);
  assign req_acc   = req.valid && req.ready;

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffca_pkg::ST_CLEAR;
      pool_size <= ffca_pkg::POOL_RESET;
      pool_n    <= ffca_pkg::POOL_RESET;
      clr_addr  <= '0;
      rsp.valid <= 1'b0;
      dv        <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ffca_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= ffca_pkg::ST_IDLE;
          end
        end
        ffca_pkg::ST_IDLE: begin
          if (req_acc) begin
            len <= req.run_length;
            if (req.mode == ffca_pkg::MODE_ALLOC) begin
              if (req.run_length == '0) begin
                res_found <= 1'b0;
                res_slot  <= '0;
                state     <= ffca_pkg::ST_RESULT;
              end else begin
                rd_addr   <= '0;
                dv        <= 1'b0;
                run       <= '0;
                run_start <= '0;
                state     <= ffca_pkg::ST_SCAN;
              end
            end else if (req.run_length != '0 && free_s <= free_e) begin
              lo        <= IW'(free_s - (SW+1)'(1));
              hi        <= IW'(free_e - (SW+1)'(1));
              mark_addr <= AW'((free_s - (SW+1)'(1)) >> BW);
              fill      <= 1'b1;
              state     <= ffca_pkg::ST_MARK_RD;
            end
          end
        end
        ffca_pkg::ST_SCAN: begin
          // Issue the next read while the previous word is examined
          if (!rd_addr[AW]) begin
            rd_addr <= rd_addr + (AW+1)'(1);
          end
          dv        <= !rd_addr[AW];
          data_addr <= rd_addr[AW-1:0];
          if (dv) begin
            run       <= sres.run;
            run_start <= sres.run_start;
            if (sres.hit) begin
              res_found <= 1'b1;
              res_slot  <= sres.hit_start;
              lo        <= IW'(sres.hit_start - SW'(1));
              hi        <= IW'(alloc_end);
              mark_addr <= AW'((sres.hit_start - SW'(1)) >> BW);
              fill      <= 1'b0;
              dv        <= 1'b0;
              state     <= ffca_pkg::ST_MARK_RD;
            end else if (data_addr == '1) begin
              res_found <= 1'b0;
              res_slot  <= '0;
              dv        <= 1'b0;
              state     <= ffca_pkg::ST_RESULT;
            end
          end
        end
        ffca_pkg::ST_MARK_RD: begin
          state <= ffca_pkg::ST_MARK_WR;
        end
        ffca_pkg::ST_MARK_WR: begin
          if (mark_addr == hi[IW-1:BW]) begin
            state <= fill ? ffca_pkg::ST_IDLE : ffca_pkg::ST_RESULT;
          end else begin
            mark_addr <= mark_addr + AW'(1);
            state     <= ffca_pkg::ST_MARK_RD;
          end
        end
        ffca_pkg::ST_RESULT: begin
          // Hold until the output register is free
          if (!rsp.valid) begin
            rsp.valid      <= 1'b1;
            rsp.first_slot <= res_slot;
            rsp.found      <= res_found;
            state          <= ffca_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ffca_pkg::ST_CLEAR;
        end
      endcase
      // Rebuild on a pool_size write
      if (cfg_wr) begin
        pool_size <= pwdata[SW-1:0];
        pool_n    <= pool_n_next;
        clr_addr  <= '0;
        state     <= ffca_pkg::ST_CLEAR;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ffca_ram.sv =====
`default_nettype none
module ffca_ram #(
  parameter int DW = 8,
  parameter int AW = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [DW-1:0]      rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ffca_scan.sv =====
`default_nettype none
module ffca_scan (
  input  wire logic [ffca_pkg::WORD_W-1:0] word,
  input  wire logic [ffca_pkg::ADDR_W-1:0] waddr,
  input  wire logic [ffca_pkg::SLOT_W-1:0] len,
  input  wire logic [ffca_pkg::SLOT_W-1:0] run_in,
  input  wire logic [ffca_pkg::SLOT_W-1:0] run_start_in,
  output ffca_pkg::scan_res_t              res
);

  // Walk the bits of one word from bit 0 upward, extending the current free run
  always_comb begin
    logic [ffca_pkg::SLOT_W-1:0] c;
    logic [ffca_pkg::SLOT_W-1:0] s;
    logic                        f;
    logic [ffca_pkg::SLOT_W-1:0] fs;
    logic [ffca_pkg::SLOT_W-1:0] pos;
    c  = run_in;
    s  = run_start_in;
    f  = 1'b0;
    fs = '0;
    for (int b = 0; b < ffca_pkg::WORD_W; b++) begin
      pos = ffca_pkg::SLOT_W'({waddr, ffca_pkg::BIT_W'(b)}) + ffca_pkg::SLOT_W'(1);
      if (word[b]) begin
        if (c == '0) begin
          s = pos;
        end
        c = c + ffca_pkg::SLOT_W'(1);
        if (!f && c >= len) begin
          f  = 1'b1;
          fs = s;
        end
      end else begin
        c = '0;
      end
    end
    res.hit       = f;
    res.hit_start = fs;
    res.run       = c;
    res.run_start = s;
  end

endmodule
`default_nettype wire
